FILE: hw/rtl/hcd_pkg.sv
`default_nettype none
package hcd_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int KEY_W = 31;
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd10;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the transaction, start hash
    logic hash_step;  // one restoring-division step
    logic rd_head;    // read the bucket head
    logic rd_node;    // issue a node read at cur
    logic adv;        // advance cur to link, remember prev
    logic ins_write;  // write the new node and link it in
    logic del_write;  // unlink cur and push it to the free stack
    logic pop;        // read the top of the free stack
    logic hit;        // latch the found value
    logic clr_init;   // write one free stack entry during the init sweep
  } hcd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hash_done;
    logic init_done;
    logic have;       // current node exists
    logic match;      // node key equals the key
    logic link_valid; // node has a successor
    logic pool_empty;
    logic steps_done;
  } hcd_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/hcd_if.sv
`default_nettype none
interface hcd_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hcd_ctrl.sv
`default_nettype none
module hcd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     op,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          status_r,
  output hcd_pkg::hcd_cmd_t   cmd,
  input  wire hcd_pkg::hcd_sts_t sts
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_HEAD, S_POP, S_RD, S_CHK, S_INS, S_DEL, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] status_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    cmd        = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_init = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_nxt     = op;
          status_nxt = hcd_pkg::ST_DONE;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.rd_head = 1'b1;
        priority if (op_r == hcd_pkg::OP_INSERT) begin
          if (sts.pool_empty) begin
            status_nxt = hcd_pkg::ST_FULL;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_POP;
          end
        end else if (op_r == hcd_pkg::OP_SEARCH || op_r == hcd_pkg::OP_DELETE) begin
          status_nxt = hcd_pkg::ST_MISS;
          state_nxt  = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        // Node read for cur; skip the walk when the chain is empty.
        if (!sts.have) begin
          state_nxt = (op_r == hcd_pkg::OP_INSERT) ? S_INS : S_OUT;
        end else begin
          cmd.rd_node = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        priority if (op_r == hcd_pkg::OP_INSERT) begin
          if (sts.link_valid && !sts.steps_done) begin
            cmd.adv   = 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_INS;
          end
        end else if (sts.match) begin
          status_nxt = hcd_pkg::ST_DONE;
          if (op_r == hcd_pkg::OP_SEARCH) begin
            cmd.hit   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DEL;
          end
        end else if (sts.link_valid && !sts.steps_done) begin
          cmd.adv   = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_INS: begin
        cmd.ins_write = 1'b1;
        state_nxt     = S_OUT;
      end
      S_DEL: begin
        cmd.del_write = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      op_r     <= hcd_pkg::OP_INSERT;
      status_r <= hcd_pkg::ST_DONE;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
    end
  end

  // The output holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status_r))
    else $error("result changed while stalled");
  // No new transaction while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output overlap");
  // Only one write command at a time.
  a_onewr: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_write, cmd.del_write, cmd.clr_init}))
    else $error("concurrent writes");
endmodule
`default_nettype wire

FILE: hw/rtl/hcd_datapath.sv
`default_nettype none
module hcd_datapath #(
  parameter int BUCKETS    = 16,
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [hcd_pkg::SIZE_W-1:0] cfg_data,
  input  wire logic [hcd_pkg::KEY_W-1:0]  key,
  input  wire logic [VALUE_BITS-1:0]    value_in,
  output logic [VALUE_BITS-1:0]         value_out_r,
  input  wire hcd_pkg::hcd_cmd_t        cmd,
  output hcd_pkg::hcd_sts_t             sts
);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int KW = hcd_pkg::KEY_W;
  localparam int HW = KW + 3;   // 3*key+5 fits here
  localparam int MW = $clog2(BUCKETS + 1);

  // Configuration register.
  logic [hcd_pkg::SIZE_W-1:0] size_r;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= hcd_pkg::SIZE_RESET;
    else if (cfg_we) size_r <= cfg_data;
  end

  // Effective modulus: zero acts as one, large values saturate.
  logic [MW-1:0] mod_eff;
  always_comb begin
    if (size_r == '0) mod_eff = MW'(1);
    else if (32'(size_r) > BUCKETS) mod_eff = MW'(BUCKETS);
    else mod_eff = MW'(size_r);
  end

  // Restoring division, one quotient bit per cycle.
  logic [KW-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HW-1:0] dvd_r, dvd_nxt;
  logic [MW:0] rem_r, rem_nxt;
  logic [$clog2(HW+1)-1:0] hcnt_r;
  logic [MW:0] trial;
  always_comb begin
    trial   = {rem_r[MW-1:0], dvd_r[HW-1]};
    dvd_nxt = {dvd_r[HW-2:0], 1'b0};
    rem_nxt = (trial >= {1'b0, mod_eff}) ? trial - {1'b0, mod_eff} : trial;
  end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key;
      val_r  <= value_in;
      dvd_r  <= HW'(key) * HW'(3) + HW'(5);
      rem_r  <= '0;
      hcnt_r <= '0;
    end else if (cmd.hash_step) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      hcnt_r <= hcnt_r + 1'b1;
    end
  end
  assign sts.hash_done = (32'(hcnt_r) == HW - 1) && cmd.hash_step;
  logic [BW-1:0] bkt_r;
  always_ff @(posedge clk) begin
    if (cmd.hash_step) bkt_r <= BW'(rem_nxt);
  end

  // Bucket table: valid bits reset, heads written before use.
  logic [BUCKETS-1:0] bvalid_r;
  logic [NW-1:0] bhead_r [BUCKETS];

  // Node pool memories.
  logic [KW-1:0] nkey_m [NODES];
  logic [VALUE_BITS-1:0] nval_m [NODES];
  logic [NW-1:0] nlink_m [NODES];
  logic [NODES-1:0] nlv_r;
  logic [NW-1:0] fstk_m [NODES];
  logic [CW-1:0] fcnt_r;
  logic [NW-1:0] init_r;

  logic [NW-1:0] cur_r, prev_r, newn_r;
  logic have_r, has_prev_r;
  logic [CW-1:0] steps_r;
  logic [KW-1:0] rkey_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [NW-1:0] rlink_r;
  logic rlv_r;

  // Node reads, registered.
  always_ff @(posedge clk) begin
    if (cmd.rd_node) begin
      rkey_r  <= nkey_m[cur_r];
      rval_r  <= nval_m[cur_r];
      rlink_r <= nlink_m[cur_r];
    end
    if (cmd.pop) newn_r <= fstk_m[NW'(fcnt_r - 1'b1)];
  end

  // Node writes and free stack.
  always_ff @(posedge clk) begin
    if (cmd.clr_init) fstk_m[init_r] <= init_r;
    if (cmd.ins_write) begin
      nkey_m[newn_r] <= key_r;
      nval_m[newn_r] <= val_r;
      if (have_r) nlink_m[cur_r] <= newn_r;
    end
    if (cmd.del_write && has_prev_r) nlink_m[prev_r] <= rlink_r;
    if (cmd.del_write && fcnt_r < CW'(NODES)) fstk_m[NW'(fcnt_r)] <= cur_r;
  end

  // Control state of the pool.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
      nlv_r    <= '0;
      fcnt_r   <= CW'(NODES);
      init_r   <= '0;
    end else begin
      if (cmd.clr_init) init_r <= init_r + 1'b1;
      if (cmd.pop) fcnt_r <= fcnt_r - 1'b1;
      if (cmd.ins_write) begin
        nlv_r[newn_r] <= 1'b0;
        if (have_r) nlv_r[cur_r] <= 1'b1;
        else bvalid_r[bkt_r] <= 1'b1;
      end
      if (cmd.del_write) begin
        if (has_prev_r) nlv_r[prev_r] <= rlv_r;
        else bvalid_r[bkt_r] <= rlv_r;
        if (fcnt_r < CW'(NODES)) fcnt_r <= fcnt_r + 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.ins_write && !have_r) bhead_r[bkt_r] <= newn_r;
    if (cmd.del_write && !has_prev_r) bhead_r[bkt_r] <= rlink_r;
  end

  // Chain walk pointers.
  always_ff @(posedge clk) begin
    if (cmd.rd_head) begin
      cur_r      <= bhead_r[bkt_r];
      have_r     <= bvalid_r[bkt_r];
      has_prev_r <= 1'b0;
      steps_r    <= '0;
    end else if (cmd.adv) begin
      prev_r     <= cur_r;
      has_prev_r <= 1'b1;
      cur_r      <= rlink_r;
      steps_r    <= steps_r + 1'b1;
    end
    if (cmd.rd_node) rlv_r <= nlv_r[cur_r];
  end

  // Result value.
  always_ff @(posedge clk) begin
    if (cmd.load) value_out_r <= '0;
    else if (cmd.hit) value_out_r <= rval_r;
  end

  assign sts.init_done  = (32'(init_r) == NODES - 1);
  assign sts.have       = have_r;
  assign sts.match      = (rkey_r == key_r);
  assign sts.link_valid = rlv_r;
  assign sts.pool_empty = (fcnt_r == '0);
  assign sts.steps_done = (32'(steps_r) >= NODES - 1);

  // The free count never exceeds the pool.
  a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= CW'(NODES)) else $error("free count overflow");
  // An insert never happens with an empty pool.
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> fcnt_r != '0) else $error("pop from empty pool");
  // The bucket index stays below the modulus.
  a_bkt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_head |-> MW'(bkt_r) < mod_eff) else $error("bucket out of range");
endmodule
`default_nettype wire

FILE: hw/rtl/hash_chain_dictionary_core.sv
// Channel  Direction  Payload
// in       sink       operation[1:0], key[30:0], value_in[VALUE_BITS-1:0]
// out      source     status[1:0], value_out[VALUE_BITS-1:0]
// cfg      write      table_size[4:0]
// One transaction at a time: hash remainder one bit per cycle, then a node
// read and a check per chain node walked, plus head, pop, write and output.
// After reset a sweep fills all NODES free stack entries; no input is taken.
// Reset is synchronous and active low; the result waits in its register
// until taken, and the next transaction is taken after that.
`default_nettype none
module hash_chain_dictionary_core #(
  parameter int BUCKETS    = 16,
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [hcd_pkg::SIZE_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [hcd_pkg::KEY_W-1:0] in_key,
  input  wire logic [VALUE_BITS-1:0] in_value_in,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [1:0] out_status,
  output logic [VALUE_BITS-1:0] out_value_out
);
  hcd_pkg::hcd_cmd_t cmd;
  hcd_pkg::hcd_sts_t sts;

  hcd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .op(in_operation),
    .out_valid, .out_ready, .status_r(out_status), .cmd, .sts
  );

  hcd_datapath #(.BUCKETS(BUCKETS), .NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_data, .key(in_key), .value_in(in_value_in),
    .value_out_r(out_value_out), .cmd, .sts
  );
endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
  localparam int KW = hcd_pkg::KEY_W;
  localparam int NBKT = 16;
  localparam int NNODE = 256;
  localparam int IN_W = 2 + KW + 64;
  localparam int OUT_W = 2 + 64;
  localparam int LIMIT = 3000000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
  } dict_reply_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hcd_pkg::SIZE_W-1:0] cfg_data;

  hcd_if #(.W(IN_W)) in_ch ();
  hcd_if #(.W(OUT_W)) out_ch ();

  hash_chain_dictionary_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_operation(in_ch.data[IN_W-1 -: 2]),
    .in_key(in_ch.data[64 +: KW]),
    .in_value_in(in_ch.data[63:0]),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_status(out_ch.data[65:64]),
    .out_value_out(out_ch.data[63:0])
  );

  // Shadow copy of the dictionary.
  logic [hcd_pkg::SIZE_W-1:0] sh_size;
  logic              sh_bkt_valid [NBKT];
  logic [7:0]        sh_bkt_head [NBKT];
  logic [KW-1:0]     sh_key [NNODE];
  logic [63:0]       sh_val [NNODE];
  logic [7:0]        sh_link [NNODE];
  logic              sh_link_ok [NNODE];
  logic [7:0]        sh_free [NNODE];
  int                sh_free_cnt;

  logic [IN_W-1:0] pending_ops[$];
  dict_reply_t     expected_replies[$];
  logic [KW-1:0]   key_pool [32];

  int  snd_idle;
  int  rcv_idle;
  int  hold_start;
  int  hold_len;
  int  cyc;
  int  err_cnt;
  int  n_full;
  int  n_hit;
  int  n_replies;
  logic in_taken;

  function automatic int bucket_of(logic [KW-1:0] k);
    longint unsigned m;
    m = 64'(sh_size);
    if (m == 0) m = 1;
    if (m > NBKT) m = NBKT;
    return int'((64'd3 * k + 64'd5) % m);
  endfunction

  // Apply one dictionary operation to the shadow and return its reply.
  task automatic apply_op(input logic [1:0] op, input logic [KW-1:0] k,
                          input logic [63:0] v, output dict_reply_t r);
    int b;
    int n;
    int cur;
    int prev;
    bit have;
    bit has_prev;
    b = bucket_of(k);
    r.status = hcd_pkg::ST_DONE;
    r.value = '0;
    if (op == hcd_pkg::OP_INSERT) begin
      if (sh_free_cnt == 0) begin
        r.status = hcd_pkg::ST_FULL;
      end else begin
        sh_free_cnt--;
        n = int'(sh_free[sh_free_cnt]);
        sh_key[n] = k;
        sh_val[n] = v;
        sh_link[n] = '0;
        sh_link_ok[n] = 1'b0;
        if (!sh_bkt_valid[b]) begin
          sh_bkt_valid[b] = 1'b1;
          sh_bkt_head[b] = n[7:0];
        end else begin
          cur = int'(sh_bkt_head[b]);
          for (int s = 0; s < NNODE && sh_link_ok[cur]; s++) cur = int'(sh_link[cur]);
          sh_link[cur] = n[7:0];
          sh_link_ok[cur] = 1'b1;
        end
      end
    end else if (op == hcd_pkg::OP_SEARCH || op == hcd_pkg::OP_DELETE) begin
      have = sh_bkt_valid[b];
      cur = int'(sh_bkt_head[b]);
      has_prev = 0;
      prev = 0;
      r.status = hcd_pkg::ST_MISS;
      for (int s = 0; s < NNODE && have; s++) begin
        if (sh_key[cur] == k) begin
          r.status = hcd_pkg::ST_DONE;
          if (op == hcd_pkg::OP_SEARCH) begin
            r.value = sh_val[cur];
          end else begin
            if (!has_prev) begin
              sh_bkt_valid[b] = sh_link_ok[cur];
              sh_bkt_head[b] = sh_link[cur];
            end else begin
              sh_link_ok[prev] = sh_link_ok[cur];
              sh_link[prev] = sh_link[cur];
            end
            if (sh_free_cnt < NNODE) begin
              sh_free[sh_free_cnt] = cur[7:0];
              sh_free_cnt++;
            end
          end
          break;
        end
        has_prev = 1;
        prev = cur;
        have = sh_link_ok[cur];
        cur = int'(sh_link[cur]);
      end
    end
  endtask

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Input driver: offers the next pending item once the last one was taken.
  always @(negedge clk) begin
    in_taken <= 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_ch.data <= pending_ops.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with a long hold-off window to back up the block.
  always @(negedge clk) begin
    if (cyc >= hold_start && cyc < hold_start + hold_len) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Input monitor: each accepted transaction updates the shadow.
  always @(posedge clk) begin
    dict_reply_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      apply_op(in_ch.data[IN_W-1 -: 2], in_ch.data[64 +: KW], in_ch.data[63:0], r);
      expected_replies.push_back(r);
      in_taken <= 1'b1;
    end
  end

  // Output monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    dict_reply_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_replies++;
      if (expected_replies.size() == 0) begin
        $error("unexpected result status=%0d value_out=%h", out_ch.data[65:64],
               out_ch.data[63:0]);
        err_cnt++;
      end else begin
        e = expected_replies.pop_front();
        if (e.status == hcd_pkg::ST_FULL) n_full++;
        if (e.status == hcd_pkg::ST_DONE && e.value != 0) n_hit++;
        if (out_ch.data[65:64] !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.data[65:64]);
          err_cnt++;
        end
        if (out_ch.data[63:0] !== e.value) begin
          $error("value_out expected %h actual %h", e.value, out_ch.data[63:0]);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [IN_W-1:0] make_op(logic [1:0] op, logic [KW-1:0] k,
                                             logic [63:0] v);
    return {op, k, v};
  endfunction

  // Random operations over a mostly reused key set.
  task automatic gen_ops(input int n, input int ins_pct, input int srch_pct);
    int p;
    logic [1:0] op;
    logic [KW-1:0] k;
    for (int i = 0; i < n; i++) begin
      p = int'($urandom_range(99));
      if (p < 4) op = OP_NONE;
      else if (p < 4 + ins_pct) op = hcd_pkg::OP_INSERT;
      else if (p < 4 + ins_pct + srch_pct) op = hcd_pkg::OP_SEARCH;
      else op = hcd_pkg::OP_DELETE;
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(31)];
      else k = KW'($urandom());
      pending_ops.push_back(make_op(op, k, {$urandom(), $urandom()}));
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_ch.valid || expected_replies.size() > 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_size(input logic [hcd_pkg::SIZE_W-1:0] v);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    sh_size = v;
    cfg_we = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    cyc = 0;
    err_cnt = 0;
    n_full = 0;
    n_hit = 0;
    n_replies = 0;
    snd_idle = 9;
    rcv_idle = 80;
    hold_start = -1;
    hold_len = 0;
    sh_size = hcd_pkg::SIZE_RESET;
    for (int i = 0; i < NBKT; i++) begin
      sh_bkt_valid[i] = 1'b0;
      sh_bkt_head[i] = '0;
    end
    for (int i = 0; i < NNODE; i++) begin
      sh_free[i] = i[7:0];
      sh_key[i] = '0;
      sh_val[i] = '0;
      sh_link[i] = '0;
      sh_link_ok[i] = 1'b0;
    end
    sh_free_cnt = NNODE;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 32; i++) key_pool[i] = KW'($urandom());
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, duplicates, collisions, misses and the unused code.
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, '0, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_DELETE, '0, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_INSERT, '0, '1));
    pending_ops.push_back(make_op(hcd_pkg::OP_INSERT, '1, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_INSERT, '0, 64'h0123_4567_89ab_cdef));
    pending_ops.push_back(make_op(hcd_pkg::OP_INSERT, 31'd10, 64'h5555_5555_5555_5555));
    pending_ops.push_back(make_op(hcd_pkg::OP_INSERT, 31'd20, 64'haaaa_aaaa_aaaa_aaaa));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, '0, '1));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, '1, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, 31'd20, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_DELETE, 31'd10, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, 31'd20, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_DELETE, '0, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, '0, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_DELETE, 31'd12345, '0));
    pending_ops.push_back(make_op(OP_NONE, '1, '1));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, 31'd10, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_DELETE, '1, '0));
    pending_ops.push_back(make_op(hcd_pkg::OP_SEARCH, '1, '0));
    wait_drained();

    // Full table, sender rarely idle, receiver mostly stalled.
    write_size(5'd16);
    snd_idle = 9;
    rcv_idle = 80;
    gen_ops(350, 45, 30);
    wait_drained();

    // Size zero acts as one bucket; sender mostly idle.
    write_size(5'd0);
    snd_idle = 80;
    rcv_idle = 9;
    gen_ops(300, 35, 35);
    wait_drained();

    // Oversized value saturates; fill the pool past full, then drain some.
    write_size(5'd31);
    snd_idle = 0;
    rcv_idle = 0;
    hold_start = cyc + 100;
    hold_len = 600;
    gen_ops(300, 90, 4);
    gen_ops(100, 10, 30);
    wait_drained();

    // Size one, then a random mid-range size, over whatever chains are left.
    write_size(5'd1);
    gen_ops(40, 30, 40);
    wait_drained();
    write_size(5'($urandom_range(15, 2)));
    gen_ops(260, 30, 35);
    wait_drained();

    $display("Ran %0d results over table sizes 10, 16, 0, 31, 1 and a random one.",
             n_replies);
    $display("Saw %0d nonzero search hits and %0d inserts rejected on a full pool.",
             n_hit, n_full);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: hash_chain_dictionary_core.f
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_if.sv
hw/rtl/hcd_ctrl.sv
hw/rtl/hcd_datapath.sv
hw/rtl/hash_chain_dictionary_core.sv
dv/tb.sv
